/* src/lens_undistort_nearest_remap_macros.svh */
// Assertion macros shared by the lens undistortion RTL.
`ifndef LENS_UNDISTORT_NEAREST_REMAP_MACROS_SVH
`define LENS_UNDISTORT_NEAREST_REMAP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LUD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LUD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lud_pkg.sv */
// Shared types, constants and microcode for the lens undistortion block.
package lud_pkg;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;

  localparam logic signed [31:0] Q_ONE = 32'sd1048576;
  localparam logic signed [31:0] Q_MAX = 32'sd8388607;
  localparam logic signed [31:0] Q_MIN = -32'sd8388608;

  // Divider runs one quotient bit per cycle over 23 bits
  localparam logic [4:0] DIV_CNT_LAST   = 5'd22;
  localparam logic [3:0] MICRO_LAST     = 4'd14;

  localparam logic [19:0] FOCAL_X_RST  = 20'd153600;
  localparam logic [19:0] FOCAL_Y_RST  = 20'd153600;
  localparam logic [17:0] CENTER_X_RST = 18'd81920;
  localparam logic [17:0] CENTER_Y_RST = 18'd61440;

  typedef enum logic [2:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_K1       = 3'd4,
    CFG_K2       = 3'd5,
    CFG_P1       = 3'd6,
    CFG_P2       = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE = 4'd0,
    MUL_XX   = 4'd1,
    MUL_YY   = 4'd2,
    MUL_XY   = 4'd3,
    MUL_R2R2 = 4'd4,
    MUL_K1R2 = 4'd5,
    MUL_K2R4 = 4'd6,
    MUL_P1XY = 4'd7,
    MUL_XRAD = 4'd8,
    MUL_P2SX = 4'd9,
    MUL_YRAD = 4'd10,
    MUL_P2XY = 4'd11,
    MUL_P1SY = 4'd12,
    MUL_FXXD = 4'd13,
    MUL_FYYD = 4'd14
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE  = 4'd0,
    WB_XX    = 4'd1,
    WB_YY    = 4'd2,
    WB_XY    = 4'd3,
    WB_R4    = 4'd4,
    WB_T1    = 4'd5,
    WB_RAD   = 4'd6,
    WB_LOAD2 = 4'd7,
    WB_ADD   = 4'd8,
    WB_XD    = 4'd9,
    WB_LOAD  = 4'd10,
    WB_ADD2  = 4'd11,
    WB_YD    = 4'd12,
    WB_UD    = 4'd13,
    WB_VD    = 4'd14
  } wb_sel_t;

  typedef struct packed {
    mul_sel_t mul;
    wb_sel_t  wb;
  } micro_t;

  typedef struct packed {
    logic   capture;
    logic   mem_write;
    logic   div_load;
    logic   div_step;
    logic   div_store;
    logic   axis;
    micro_t micro;
    logic   addr_calc;
    logic   mem_read;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Clamp to the signed Q4.20 range
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[23:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Shared multiplier program: a product issued at one step is written back at the next
  function automatic micro_t micro_rom(input logic [3:0] step);
    micro_t m;
    case (step)
      4'd0:    m = '{mul: MUL_XX,   wb: WB_NONE};
      4'd1:    m = '{mul: MUL_YY,   wb: WB_XX};
      4'd2:    m = '{mul: MUL_XY,   wb: WB_YY};
      4'd3:    m = '{mul: MUL_R2R2, wb: WB_XY};
      4'd4:    m = '{mul: MUL_K1R2, wb: WB_R4};
      4'd5:    m = '{mul: MUL_K2R4, wb: WB_T1};
      4'd6:    m = '{mul: MUL_P1XY, wb: WB_RAD};
      4'd7:    m = '{mul: MUL_XRAD, wb: WB_LOAD2};
      4'd8:    m = '{mul: MUL_P2SX, wb: WB_ADD};
      4'd9:    m = '{mul: MUL_YRAD, wb: WB_XD};
      4'd10:   m = '{mul: MUL_P2XY, wb: WB_LOAD};
      4'd11:   m = '{mul: MUL_P1SY, wb: WB_ADD2};
      4'd12:   m = '{mul: MUL_FXXD, wb: WB_YD};
      4'd13:   m = '{mul: MUL_FYYD, wb: WB_UD};
      4'd14:   m = '{mul: MUL_NONE, wb: WB_VD};
      default: m = '{mul: MUL_NONE, wb: WB_NONE};
    endcase
    return m;
  endfunction

endpackage

/* src/lud_ctrl.sv */
// Controller state machine sequencing divider, multiplier program and frame read.
`include "lens_undistort_nearest_remap_macros.svh"

module lud_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             operation,
  output logic             in_stall,
  output lud_pkg::cmd_t    cmd,
  input  lud_pkg::status_t status
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_DIV_LOAD  = 8'b0000_0010,
    ST_DIV_RUN   = 8'b0000_0100,
    ST_DIV_STORE = 8'b0000_1000,
    ST_MICRO     = 8'b0001_0000,
    ST_ADDR      = 8'b0010_0000,
    ST_READ      = 8'b0100_0000,
    ST_FINISH    = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [4:0] div_cnt, div_cnt_next;
  logic [3:0] step, step_next;
  logic       axis, axis_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // Advance state and emit commands
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    step_next    = step;
    axis_next    = axis;
    cmd          = '0;
    cmd.axis     = axis;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation) begin
            cmd.capture = 1'b1;
            axis_next   = 1'b0;
            state_next  = ST_DIV_LOAD;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 5'd1;
        if (div_cnt == lud_pkg::DIV_CNT_LAST) begin
          state_next = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (axis) begin
          step_next  = '0;
          state_next = ST_MICRO;
        end else begin
          axis_next  = 1'b1;
          state_next = ST_DIV_LOAD;
        end
      end
      ST_MICRO: begin
        cmd.micro = lud_pkg::micro_rom(step);
        step_next = step + 4'd1;
        if (step == lud_pkg::MICRO_LAST) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = ST_READ;
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      step    <= '0;
      axis    <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      step    <= step_next;
      axis    <= axis_next;
    end
  end

  `LUD_ASSERT_NEXT(a_read_starts_x, accept && operation, state == ST_DIV_LOAD && !axis, "read did not start x division")
  `LUD_ASSERT_NEXT(a_y_then_micro, state == ST_DIV_STORE && axis, state == ST_MICRO && step == 4'd0, "micro program not entered after y")
  `LUD_ASSERT_NOW(a_out_free, cmd.out_load, status.out_free, "result loaded over a pending transaction")

endmodule

/* src/lud_datapath.sv */
// Datapath: configuration, divider, shared multiplier, frame store and output register.
module lud_datapath #(
  parameter int FRAME_WIDTH  = lud_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = lud_pkg::FRAME_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lud_pkg::cmd_t     cmd,
  output lud_pkg::status_t  status,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [23:0]       cfg_data,
  input  logic [9:0]        col,
  input  logic [8:0]        row,
  input  logic [7:0]        pixel_in,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        pixel_out,
  output logic              inside_res
);

  localparam int CW    = $clog2(FRAME_WIDTH);
  localparam int RW    = $clog2(FRAME_HEIGHT);
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [31:0] U_LIMIT = 32'(FRAME_WIDTH * 256);
  localparam logic signed [31:0] V_LIMIT = 32'(FRAME_HEIGHT * 256);

  logic [19:0]        focal_x, focal_y;
  logic [17:0]        center_x, center_y;
  logic signed [23:0] radial_k1, radial_k2, tangential_p1, tangential_p2;
  logic [19:0]        fx_eff, fy_eff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= lud_pkg::FOCAL_X_RST;
      focal_y       <= lud_pkg::FOCAL_Y_RST;
      center_x      <= lud_pkg::CENTER_X_RST;
      center_y      <= lud_pkg::CENTER_Y_RST;
      radial_k1     <= '0;
      radial_k2     <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_we) begin
      case (lud_pkg::cfg_idx_t'(cfg_addr))
        lud_pkg::CFG_FOCAL_X:  focal_x       <= cfg_data[19:0];
        lud_pkg::CFG_FOCAL_Y:  focal_y       <= cfg_data[19:0];
        lud_pkg::CFG_CENTER_X: center_x      <= cfg_data[17:0];
        lud_pkg::CFG_CENTER_Y: center_y      <= cfg_data[17:0];
        lud_pkg::CFG_K1:       radial_k1     <= cfg_data;
        lud_pkg::CFG_K2:       radial_k2     <= cfg_data;
        lud_pkg::CFG_P1:       tangential_p1 <= cfg_data;
        lud_pkg::CFG_P2:       tangential_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero focal length acts as one LSB
  assign fx_eff = (focal_x == '0) ? 20'd1 : focal_x;
  assign fy_eff = (focal_y == '0) ? 20'd1 : focal_y;

  // Capture the read coordinates
  logic [9:0] col_q;
  logic [8:0] row_q;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= col;
      row_q <= row;
    end
  end

  // Divider operands for the selected axis
  logic [9:0]         div_pix;
  logic [17:0]        div_center;
  logic [19:0]        div_f;
  logic signed [18:0] dx;
  logic [18:0]        dmag;
  logic               dsat;
  assign div_pix    = cmd.axis ? {1'b0, row_q} : col_q;
  assign div_center = cmd.axis ? center_y : center_x;
  assign div_f      = cmd.axis ? fy_eff : fx_eff;
  assign dx         = $signed({1'b0, div_pix, 8'b0}) - $signed({1'b0, div_center});
  assign dmag       = dx[18] ? 19'(-dx) : 19'(dx);
  assign dsat       = {4'b0, dmag} >= {div_f, 3'b0};

  logic [19:0] rem;
  logic [22:0] dsh, quo;
  logic        dneg, dsat_q;
  logic [20:0] trial;
  logic        trial_ge;
  assign trial    = {rem, dsh[22]};
  assign trial_ge = trial >= {1'b0, div_f};

  logic signed [23:0] qval;
  always_comb begin
    if (dsat_q) begin
      qval = dneg ? lud_pkg::Q_MIN[23:0] : lud_pkg::Q_MAX[23:0];
    end else begin
      qval = dneg ? 24'(-$signed({1'b0, quo})) : $signed({1'b0, quo});
    end
  end

  // Restoring division of |dx|*2^20 by the focal length, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem    <= {4'b0, dmag[18:3]};
      dsh    <= {dmag[2:0], 20'b0};
      quo    <= '0;
      dneg   <= dx[18];
      dsat_q <= dsat;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? 20'(trial - {1'b0, div_f}) : trial[19:0];
      dsh <= {dsh[21:0], 1'b0};
      quo <= {quo[21:0], trial_ge};
    end
  end

  logic signed [23:0] x, y, xx, yy, xy, r2, r4, rad, xd, yd;
  logic signed [25:0] sx, sy;
  logic signed [31:0] acc, ud, vd;
  logic signed [26:0] opa;
  logic signed [24:0] opb;
  logic signed [51:0] prod;
  logic signed [31:0] pf;

  assign pf = prod[51:20];

  // Select multiplier operands
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.micro.mul)
      lud_pkg::MUL_XX:   begin opa = 27'(x);             opb = 25'(x);   end
      lud_pkg::MUL_YY:   begin opa = 27'(y);             opb = 25'(y);   end
      lud_pkg::MUL_XY:   begin opa = 27'(x);             opb = 25'(y);   end
      lud_pkg::MUL_R2R2: begin opa = 27'(r2);            opb = 25'(r2);  end
      lud_pkg::MUL_K1R2: begin opa = 27'(radial_k1);     opb = 25'(r2);  end
      lud_pkg::MUL_K2R4: begin opa = 27'(radial_k2);     opb = 25'(r4);  end
      lud_pkg::MUL_P1XY: begin opa = 27'(tangential_p1); opb = 25'(xy);  end
      lud_pkg::MUL_XRAD: begin opa = 27'(x);             opb = 25'(rad); end
      lud_pkg::MUL_P2SX: begin opa = 27'(sx);            opb = 25'(tangential_p2); end
      lud_pkg::MUL_YRAD: begin opa = 27'(y);             opb = 25'(rad); end
      lud_pkg::MUL_P2XY: begin opa = 27'(tangential_p2); opb = 25'(xy);  end
      lud_pkg::MUL_P1SY: begin opa = 27'(sy);            opb = 25'(tangential_p1); end
      lud_pkg::MUL_FXXD: begin opa = $signed({7'b0, fx_eff}); opb = 25'(xd); end
      lud_pkg::MUL_FYYD: begin opa = $signed({7'b0, fy_eff}); opb = 25'(yd); end
      default: ;
    endcase
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  // Tangential operands r2 + 2*xx and r2 + 2*yy
  always_ff @(posedge clk) begin
    sx <= 26'(r2) + 26'(xx) + 26'(xx);
    sy <= 26'(r2) + 26'(yy) + 26'(yy);
  end

  // Store division quotients and write back rescaled products
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (cmd.axis) begin
        y <= qval;
      end else begin
        x <= qval;
      end
    end
    case (cmd.micro.wb)
      lud_pkg::WB_XX:    xx  <= lud_pkg::sat24(pf);
      lud_pkg::WB_YY: begin
        yy <= lud_pkg::sat24(pf);
        r2 <= lud_pkg::sat24(32'(xx) + 32'(lud_pkg::sat24(pf)));
      end
      lud_pkg::WB_XY:    xy  <= lud_pkg::sat24(pf);
      lud_pkg::WB_R4:    r4  <= lud_pkg::sat24(pf);
      lud_pkg::WB_T1:    acc <= lud_pkg::Q_ONE + pf;
      lud_pkg::WB_RAD:   rad <= lud_pkg::sat24(acc + pf);
      lud_pkg::WB_LOAD2: acc <= {pf[30:0], 1'b0};
      lud_pkg::WB_ADD:   acc <= acc + pf;
      lud_pkg::WB_XD:    xd  <= lud_pkg::sat24(acc + pf);
      lud_pkg::WB_LOAD:  acc <= pf;
      lud_pkg::WB_ADD2:  acc <= acc + $signed({pf[30:0], 1'b0});
      lud_pkg::WB_YD:    yd  <= lud_pkg::sat24(acc + pf);
      lud_pkg::WB_UD:    ud  <= pf + $signed({14'b0, center_x});
      lud_pkg::WB_VD:    vd  <= pf + $signed({14'b0, center_y});
      default: ;
    endcase
  end

  // Bounds check and source address
  logic          inside_c, inside_q;
  logic [CW-1:0] sc;
  logic [RW-1:0] sr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_ok;
  assign inside_c = !ud[31] && (ud < U_LIMIT) && !vd[31] && (vd < V_LIMIT);
  assign sc       = ud[8 +: CW];
  assign sr       = vd[8 +: RW];
  assign wr_ok    = (32'(col) < 32'(FRAME_WIDTH)) && (32'(row) < 32'(FRAME_HEIGHT));
  assign wr_addr  = AW'(32'(row) * 32'(FRAME_WIDTH) + 32'(col));

  always_ff @(posedge clk) begin
    if (cmd.addr_calc) begin
      inside_q <= inside_c;
      rd_addr  <= AW'(32'(sr) * 32'(FRAME_WIDTH) + 32'(sc));
    end
  end

  // Frame store
  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_ok) begin
      mem[wr_addr] <= pixel_in;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Output register: load a result, drop it once taken
  assign status.out_free = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out  <= inside_q ? mem_q : 8'd0;
      inside_res <= inside_q;
    end
  end

endmodule

/* src/lens_undistort_nearest_remap.sv */
// Top level of the Brown-Conrady nearest-neighbor lens undistortion block.
//
//  channel   handshake            payload
//  input     in_valid / in_stall  operation, col, row, pixel_in
//  output    out_valid/out_stall  pixel_out, inside_res
//  config    cfg_we               cfg_addr, cfg_data
//
// A pixel write does not stall the input. A read stalls the input through
// two divisions (load, 23 restoring steps at one quotient bit a cycle,
// store), a 15-step program on the single 27x25 multiplier, then address,
// frame store read and output load, which waits until the output register
// is free. Reset is synchronous and clears control state; the frame store
// is not cleared. A stalled result stays in the output register while the
// next transaction is already accepted.
module lens_undistort_nearest_remap #(
  parameter int FRAME_WIDTH  = lud_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = lud_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [9:0]  col,
  input  logic [8:0]  row,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  output logic        inside_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data
);

  lud_pkg::cmd_t    cmd;
  lud_pkg::status_t status;

  lud_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lud_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .col        (col),
    .row        (row),
    .pixel_in   (pixel_in),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .pixel_out  (pixel_out),
    .inside_res (inside_res)
  );

endmodule
